>>> sv/pc_pkg.sv
package pc_pkg;

   localparam int BYTE_W        = 8;
   localparam int HASH_BITS_DEF = 16;
   localparam int HASH_SHIFT    = 4;
   localparam int GROUP_SIZE    = 8;
   localparam int FILL_W        = $clog2(GROUP_SIZE);
   localparam int COUNT_W       = FILL_W + 1;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   localparam logic [FILL_W-1:0] GROUP_LAST = FILL_W'(GROUP_SIZE - 1);

   // one finished group handed from the front to the back
   typedef struct packed {
      logic                                end_pkt;
      logic [COUNT_W-1:0]                  count;
      logic [BYTE_W-1:0]                   flags;
      logic [GROUP_SIZE-1:0][BYTE_W-1:0]   lits;
   } group_type;

endpackage

>>> sv/pc_channels.sv
interface pc_req_if import pc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              packet_end;

   modport source (output valid, output in_byte, output packet_end, input ready);
   modport sink   (input valid, input in_byte, input packet_end, output ready);
endinterface

interface pc_rsp_if import pc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              is_flag_byte;
   logic              run_last;
   logic              packet_done;

   modport source (output valid, output out_byte, output is_flag_byte,
                   output run_last, output packet_done, input ready);
   modport sink   (input valid, input out_byte, input is_flag_byte,
                   input run_last, input packet_done, output ready);
endinterface

>>> sv/predictor_one_compressor.sv
// predictor-1 compressor: one packet byte per item in, compressed bytes out
// throughput: one input item per cycle unless the table is clearing or the group queue is full;
//   one result per cycle while rsp is ready, so groups of eight literals (nine results each) hold input back
// path: a flushing item's flag byte reaches rsp through the compare stage, the group queue and the output register
// reset: hash and group state clear at once; the guess table is then swept to zero over all its
//   2**HASH_BITS entries (65536 by default), and no item is accepted until the sweep is done
module predictor_one_compressor import pc_pkg::*; #(
   parameter int HASH_BITS = HASH_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   pc_req_if.sink    req_ch,
   pc_rsp_if.source  rsp_ch
);

   // finished groups move front -> queue -> back
   group_type  push_data;
   group_type  head;
   logic       push;
   logic       pop;
   logic       full;
   logic       empty;

   // front: hash, guess table lookup and update, flag and literal gathering.
   // the table read is registered, so a lookup that hits the index written
   // by the item just ahead takes that item's byte instead
   pc_front #(
      .HASH_BITS (HASH_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_full  (full),
      .q_push  (push),
      .q_data  (push_data)
   );

   // two groups deep: the front keeps taking bytes while the back drains
   pc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (full),
      .empty     (empty),
      .head      (head)
   );

   // back: flag byte then literals, one per cycle while rsp is ready, through an output register
   pc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (empty),
      .q_head  (head),
      .q_pop   (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

>>> sv/pc_front.sv
module pc_front import pc_pkg::*; #(
   parameter int HASH_BITS = HASH_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pc_req_if.sink     req_ch,
   input  logic       q_full,
   output logic       q_push,
   output group_type  q_data
);

   localparam int TABLE_DEPTH = 1 << HASH_BITS;

   logic [BYTE_W-1:0]      guess_mem [TABLE_DEPTH];

   logic [HASH_BITS:0]     clear_ff;
   logic [HASH_BITS-1:0]   hash_ff, hash_in;
   logic                   b_valid_ff, b_valid_in;
   logic [BYTE_W-1:0]      b_byte_ff;
   logic                   b_end_ff;
   logic [HASH_BITS-1:0]   b_idx_ff;
   logic                   b_fwd_ff;
   logic [BYTE_W-1:0]      fwd_byte_ff;
   logic [BYTE_W-1:0]      rd_data_ff;

   logic [BYTE_W-1:0]                  flags_ff, flags_in;
   logic [FILL_W-1:0]                  fill_ff, fill_in;
   logic [COUNT_W-1:0]                 lcount_ff, lcount_in;
   logic [GROUP_SIZE-1:0][BYTE_W-1:0]  lits_ff, lits_in;

   logic                   clearing;
   logic                   accept;
   logic [BYTE_W-1:0]      guess;
   logic                   hit;
   logic                   flush;
   logic                   b_stall;
   logic                   b_go;
   logic                   mem_we;
   logic [HASH_BITS-1:0]   mem_waddr;
   logic [BYTE_W-1:0]      mem_wdata;

   assign clearing = !clear_ff[HASH_BITS];
   assign accept   = req_ch.valid && req_ch.ready;

   // previous item's byte is what the table holds at its index afterwards
   assign guess   = b_fwd_ff ? fwd_byte_ff : rd_data_ff;
   assign hit     = (guess == b_byte_ff);
   assign flush   = b_end_ff || (fill_ff == GROUP_LAST);
   assign b_stall = b_valid_ff && flush && q_full;
   assign b_go    = b_valid_ff && !b_stall;

   assign req_ch.ready = !clearing && !b_stall;

   assign mem_we    = clearing || (b_go && !hit);
   assign mem_waddr = clearing ? clear_ff[HASH_BITS-1:0] : b_idx_ff;
   assign mem_wdata = clearing ? '0 : b_byte_ff;

   assign hash_in = (hash_ff << HASH_SHIFT) ^ HASH_BITS'(req_ch.in_byte);

   always_comb begin
      b_valid_in = b_valid_ff;
      if (accept) begin
         b_valid_in = 1'b1;
      end else if (b_go) begin
         b_valid_in = 1'b0;
      end
   end

   always_comb begin
      flags_in  = flags_ff;
      lits_in   = lits_ff;
      lcount_in = lcount_ff;
      if (hit) begin
         flags_in[fill_ff] = 1'b1;
      end else begin
         lits_in[lcount_ff[FILL_W-1:0]] = b_byte_ff;
         lcount_in = lcount_ff + COUNT_W'(1);
      end
      fill_in = fill_ff + FILL_W'(1);
   end

   assign q_push         = b_go && flush;
   assign q_data.end_pkt = b_end_ff;
   assign q_data.count   = lcount_in;
   assign q_data.flags   = flags_in;
   assign q_data.lits    = lits_in;

   // table port: clearing sweep or miss write, read on accept
   always_ff @(posedge clock) begin
      if (mem_we) begin
         guess_mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         rd_data_ff <= guess_mem[hash_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff   <= '0;
         hash_ff    <= '0;
         b_valid_ff <= 1'b0;
         flags_ff   <= '0;
         fill_ff    <= '0;
         lcount_ff  <= '0;
      end else begin
         if (clearing) begin
            clear_ff <= clear_ff + (HASH_BITS+1)'(1);
         end
         if (accept) begin
            hash_ff <= hash_in;
         end
         b_valid_ff <= b_valid_in;
         if (b_go) begin
            if (flush) begin
               flags_ff  <= '0;
               fill_ff   <= '0;
               lcount_ff <= '0;
            end else begin
               flags_ff  <= flags_in;
               fill_ff   <= fill_in;
               lcount_ff <= lcount_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_byte_ff   <= req_ch.in_byte;
         b_end_ff    <= req_ch.packet_end;
         b_idx_ff    <= hash_ff;
         b_fwd_ff    <= b_valid_ff && (b_idx_ff == hash_ff);
         fwd_byte_ff <= b_byte_ff;
      end
      if (b_go && !flush) begin
         lits_ff <= lits_in;
      end
   end

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> b_valid_ff)
      else $error("accepted item did not reach compare stage");

   a_no_work_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !b_valid_ff && !q_push)
      else $error("item in flight during table clear");

endmodule

>>> sv/pc_queue.sv
module pc_queue import pc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  group_type  push_data,
   input  logic       pop,
   output logic       full,
   output logic       empty,
   output group_type  head
);

   group_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W:0]     used_ff;

   assign full  = (used_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (used_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            used_ff <= used_ff + (QPTR_W+1)'(1);
         end else if (pop && !push) begin
            used_ff <= used_ff - (QPTR_W+1)'(1);
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("group queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("group queue underflow");

endmodule

>>> sv/pc_back.sv
module pc_back import pc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  group_type  q_head,
   output logic       q_pop,
   pc_rsp_if.source   rsp_ch
);

   // position within the group: flag byte first, then literals
   logic [COUNT_W-1:0]  pos_ff;
   logic                rsp_valid_ff;
   logic [BYTE_W-1:0]   out_byte_ff;
   logic                is_flag_ff;
   logic                run_last_ff;
   logic                done_ff;

   logic                emit;
   logic                last;
   logic [FILL_W-1:0]   lit_idx;
   logic [BYTE_W-1:0]   sel_byte;

   assign emit     = !q_empty && (!rsp_valid_ff || rsp_ch.ready);
   assign last     = (pos_ff == q_head.count);
   assign lit_idx  = FILL_W'(pos_ff - COUNT_W'(1));
   assign sel_byte = (pos_ff == '0) ? q_head.flags : q_head.lits[lit_idx];
   assign q_pop    = emit && last;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_byte     = out_byte_ff;
   assign rsp_ch.is_flag_byte = is_flag_ff;
   assign rsp_ch.run_last     = run_last_ff;
   assign rsp_ch.packet_done  = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
            pos_ff       <= last ? '0 : pos_ff + COUNT_W'(1);
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff <= sel_byte;
         is_flag_ff  <= (pos_ff == '0);
         run_last_ff <= last;
         done_ff     <= last && q_head.end_pkt;
      end
   end

   a_pos_in_group: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> pos_ff <= q_head.count)
      else $error("emit position beyond literal count");

endmodule
